/* src/tws_pkg.sv */
// Package: shared types, constants and CORDIC tables for the trajectory smoother.
`timescale 1ns / 1ps
`default_nettype none
package tws_pkg;
    localparam int MAX_RADIUS_DEF   = 15;
    localparam int CORDIC_STEPS_DEF = 14;
    localparam int TABLE_LEN        = 20;
    localparam int RING_DEPTH       = 32;
    localparam int PTR_W            = 5;
    localparam int HIST_CAP         = 31;
    localparam int ZW               = 34;
    localparam int XW               = 36;
    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [XW-1:0] GAIN_START  = 36'sd2547003;

    typedef struct packed {
        logic signed [15:0] rotation_cos;
        logic signed [15:0] rotation_sin;
        logic signed [23:0] shift_x;
        logic signed [23:0] shift_y;
        logic               final_frame;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] smooth_cos;
        logic signed [15:0] smooth_sin;
        logic signed [23:0] smooth_x;
        logic signed [23:0] smooth_y;
        logic signed [15:0] smooth_angle;
        logic               last_out;
    } t_out_item;

    // controller -> datapath commands
    typedef struct packed {
        logic load_in;      // capture input and start atan2
        logic atan_step;
        logic ring_write;
        logic acc_clear;
        logic acc_step;     // add one window tap
        logic div_start;
        logic div_step;
        logic sc_start;
        logic sc_step;
        logic out_load;
        logic [5:0] tap_age; // clamped age of the tap to read
        logic last_flag;
    } t_cmd;

    typedef struct packed {
        logic final_frame;
    } t_sts;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] v;
        case (i)
            5'd0:  v = 34'sh3243F6A8;
            5'd1:  v = 34'sh1DAC6705;
            5'd2:  v = 34'sh0FADBAFC;
            5'd3:  v = 34'sh07F56EA6;
            5'd4:  v = 34'sh03FEAB76;
            5'd5:  v = 34'sh01FFD55B;
            5'd6:  v = 34'sh00FFFAAA;
            5'd7:  v = 34'sh007FFF55;
            5'd8:  v = 34'sh003FFFEA;
            5'd9:  v = 34'sh001FFFFD;
            5'd10: v = 34'sh000FFFFF;
            5'd11: v = 34'sh0007FFFF;
            5'd12: v = 34'sh0003FFFF;
            5'd13: v = 34'sh0001FFFF;
            5'd14: v = 34'sh0000FFFF;
            5'd15: v = 34'sh00007FFF;
            5'd16: v = 34'sh00003FFF;
            5'd17: v = 34'sh00001FFF;
            5'd18: v = 34'sh00000FFF;
            5'd19: v = 34'sh000007FF;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

/* src/tws_datapath.sv */
// Datapath: atan2 CORDIC, sample rings, window accumulator, divider, sin/cos CORDIC.
`timescale 1ns / 1ps
`default_nettype none
module tws_datapath (
    input  wire                 i_clk,
    input  tws_pkg::t_in_item   i_item,
    input  tws_pkg::t_cmd       i_cmd,
    input  wire [4:0]           i_step,    // CORDIC / divider iteration index
    input  wire [4:0]           i_cnt,     // window length 2r+1 (<=31)
    input  wire [4:0]           i_wptr,    // ring write pointer
    output tws_pkg::t_sts       o_sts,
    output tws_pkg::t_out_item  o_item
);
    import tws_pkg::*;

    // rings
    logic signed [15:0] angle_ring [RING_DEPTH];
    logic signed [23:0] x_ring     [RING_DEPTH];
    logic signed [23:0] y_ring     [RING_DEPTH];
    logic signed [15:0] r_rd_a;
    logic signed [23:0] r_rd_x, r_rd_y;

    logic               r_fin;
    logic signed [23:0] r_sx_in, r_sy_in;
    logic signed [XW-1:0] r_ax, r_ay;
    logic signed [ZW-1:0] r_az;
    logic signed [15:0] atan_res;
    logic signed [ZW-1:0] z_rnd;

    assign z_rnd = (r_az + ZW'(65536)) >>> 17;
    always_comb begin
        if (z_rnd > ZW'(32767))
            atan_res = 16'sh7FFF;
        else if (z_rnd < -ZW'(32768))
            atan_res = 16'sh8000;
        else
            atan_res = z_rnd[15:0];
    end

    // atan2 vectoring step
    logic signed [XW-1:0] ax_sh, ay_sh;
    assign ax_sh = r_ax >>> i_step;
    assign ay_sh = r_ay >>> i_step;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_fin   <= i_item.final_frame;
            r_sx_in <= i_item.shift_x;
            r_sy_in <= i_item.shift_y;
            if (i_item.rotation_cos < 0) begin
                r_ax <= -(XW'(i_item.rotation_cos) <<< 8);
                r_ay <= -(XW'(i_item.rotation_sin) <<< 8);
                r_az <= (i_item.rotation_sin >= 0) ? PI_Q30 : -PI_Q30;
            end else begin
                r_ax <= XW'(i_item.rotation_cos) <<< 8;
                r_ay <= XW'(i_item.rotation_sin) <<< 8;
                r_az <= '0;
            end
        end else if (i_cmd.atan_step && !(r_ax == '0 && r_ay == '0)) begin
            if (r_ay >= 0) begin
                r_ax <= r_ax + ay_sh;
                r_ay <= r_ay - ax_sh;
                r_az <= r_az + atan_entry(i_step);
            end else begin
                r_ax <= r_ax - ay_sh;
                r_ay <= r_ay + ax_sh;
                r_az <= r_az - atan_entry(i_step);
            end
        end
    end
    // zero vector stays zero through all steps, so z stays 0 and gives angle 0

    logic [4:0] rd_idx;
    assign rd_idx = i_wptr - 5'd1 - i_cmd.tap_age[4:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_write) begin
            angle_ring[i_wptr] <= atan_res;
            x_ring[i_wptr]     <= r_sx_in;
            y_ring[i_wptr]     <= r_sy_in;
        end
        r_rd_a <= angle_ring[rd_idx];
        r_rd_x <= x_ring[rd_idx];
        r_rd_y <= y_ring[rd_idx];
    end

    // accumulators: 31 taps max
    logic signed [20:0] r_sa;
    logic signed [28:0] r_sxs, r_sys;
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clear) begin
            r_sa <= '0; r_sxs <= '0; r_sys <= '0;
        end else if (i_cmd.acc_step) begin
            r_sa  <= r_sa + 21'(r_rd_a);
            r_sxs <= r_sxs + 29'(r_rd_x);
            r_sys <= r_sys + 29'(r_rd_y);
        end
    end

    // three restoring dividers on magnitudes, one quotient bit per step
    localparam int NW = 29;
    logic [NW-1:0] r_na, r_nx, r_ny, r_qa, r_qx, r_qy;
    logic [NW:0]   r_ra, r_rx, r_ry;
    logic          r_ga, r_gx, r_gy;
    logic [NW:0]   ra_t, rx_t, ry_t;
    logic [NW:0]   dv;
    assign dv   = (NW+1)'(i_cnt);
    assign ra_t = {r_ra[NW-1:0], r_na[NW-1]};
    assign rx_t = {r_rx[NW-1:0], r_nx[NW-1]};
    assign ry_t = {r_ry[NW-1:0], r_ny[NW-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_ga <= r_sa[20];  r_gx <= r_sxs[28]; r_gy <= r_sys[28];
            r_na <= NW'((r_sa[20]  ? -29'(r_sa) : 29'(r_sa)) + 29'(i_cnt >> 1));
            r_nx <= (r_sxs[28] ? -r_sxs : r_sxs) + 29'(i_cnt >> 1);
            r_ny <= (r_sys[28] ? -r_sys : r_sys) + 29'(i_cnt >> 1);
            r_ra <= '0; r_rx <= '0; r_ry <= '0;
        end else if (i_cmd.div_step) begin
            r_na <= r_na << 1; r_nx <= r_nx << 1; r_ny <= r_ny << 1;
            if (ra_t >= dv) begin r_ra <= ra_t - dv; r_qa <= {r_qa[NW-2:0], 1'b1}; end
            else begin r_ra <= ra_t; r_qa <= {r_qa[NW-2:0], 1'b0}; end
            if (rx_t >= dv) begin r_rx <= rx_t - dv; r_qx <= {r_qx[NW-2:0], 1'b1}; end
            else begin r_rx <= rx_t; r_qx <= {r_qx[NW-2:0], 1'b0}; end
            if (ry_t >= dv) begin r_ry <= ry_t - dv; r_qy <= {r_qy[NW-2:0], 1'b1}; end
            else begin r_ry <= ry_t; r_qy <= {r_qy[NW-2:0], 1'b0}; end
        end
    end

    logic signed [15:0] avg_a;
    logic signed [23:0] avg_x, avg_y;
    assign avg_a = r_ga ? -16'(r_qa) : 16'(r_qa);
    assign avg_x = r_gx ? -24'(r_qx) : 24'(r_qx);
    assign avg_y = r_gy ? -24'(r_qy) : 24'(r_qy);

    // sin/cos rotation CORDIC
    logic signed [XW-1:0] r_cx, r_cy;
    logic signed [ZW-1:0] r_cz;
    logic                 r_neg;
    logic signed [15:0]   r_ang;
    logic signed [ZW-1:0] z0;
    logic signed [XW-1:0] cx_sh, cy_sh;
    assign z0    = ZW'(avg_a) <<< 17;
    assign cx_sh = r_cx >>> i_step;
    assign cy_sh = r_cy >>> i_step;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sc_start) begin
            r_ang <= avg_a;
            r_cx  <= GAIN_START;
            r_cy  <= '0;
            if (z0 > HALF_PI_Q30) begin
                r_cz <= z0 - PI_Q30; r_neg <= 1'b1;
            end else if (z0 < -HALF_PI_Q30) begin
                r_cz <= z0 + PI_Q30; r_neg <= 1'b1;
            end else begin
                r_cz <= z0; r_neg <= 1'b0;
            end
        end else if (i_cmd.sc_step) begin
            if (r_cz >= 0) begin
                r_cx <= r_cx - cy_sh; r_cy <= r_cy + cx_sh;
                r_cz <= r_cz - atan_entry(i_step);
            end else begin
                r_cx <= r_cx + cy_sh; r_cy <= r_cy - cx_sh;
                r_cz <= r_cz + atan_entry(i_step);
            end
        end
    end

    logic signed [XW-1:0] cr, sr;
    logic signed [15:0]   c_cl, s_cl;
    always_comb begin
        cr = (r_cx + XW'(128)) >>> 8;
        sr = (r_cy + XW'(128)) >>> 8;
        if (r_neg) begin
            cr = -cr; sr = -sr;
        end
        c_cl = (cr > XW'(16384)) ? 16'sd16384 : (cr < -XW'(16384)) ? -16'sd16384 : cr[15:0];
        s_cl = (sr > XW'(16384)) ? 16'sd16384 : (sr < -XW'(16384)) ? -16'sd16384 : sr[15:0];
    end

    t_out_item r_out;
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.smooth_cos   <= c_cl;
            r_out.smooth_sin   <= s_cl;
            r_out.smooth_x     <= avg_x;
            r_out.smooth_y     <= avg_y;
            r_out.smooth_angle <= r_ang;
            r_out.last_out     <= i_cmd.last_flag;
        end
    end
    assign o_item = r_out;
    assign o_sts.final_frame = r_fin;
endmodule
`default_nettype wire

/* src/tws_ctrl.sv */
// Controller: sequences atan2, ring write, window sums, division and sin/cos per result.
`timescale 1ns / 1ps
`default_nettype none
module tws_ctrl #(
    parameter int MAX_RADIUS   = tws_pkg::MAX_RADIUS_DEF,
    parameter int CORDIC_STEPS = tws_pkg::CORDIC_STEPS_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire [3:0]     i_radius,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire           i_out_ready,
    input  tws_pkg::t_sts i_sts,
    output tws_pkg::t_cmd o_cmd,
    output logic [4:0]    o_step,
    output logic [4:0]    o_cnt,
    output logic [4:0]    o_wptr
);
    import tws_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_ATAN = 4'd1, S_WRITE = 4'd2,
                           S_DECIDE = 4'd3, S_TAP = 4'd4, S_TAPLAST = 4'd5,
                           S_DIV = 4'd6, S_SC = 4'd7, S_OUT = 4'd8, S_NEXT = 4'd9;
    localparam int DIVN = 29;

    logic [3:0] r_state, n_state;
    logic [4:0] r_step, n_step;
    logic [4:0] r_wptr, n_wptr;
    logic [5:0] r_seen, n_seen;
    logic [4:0] r_d, n_d;
    logic [5:0] r_k, n_k;      // tap index 0..2r
    logic [3:0] r_r, n_r;
    logic       r_ovalid, n_ovalid;

    logic [3:0] eff_radius;
    assign eff_radius = (32'(i_radius) > MAX_RADIUS) ? 4'(MAX_RADIUS) : i_radius;

    // age a = d - (k - r), clamped to [0, n-1]
    logic signed [7:0] age;
    logic [5:0] age_c;
    always_comb begin
        age = $signed({3'b0, r_d}) + $signed({4'b0, r_r}) - $signed({2'b0, r_k});
        if (age < 0) age_c = '0;
        else if (age > $signed({2'b0, r_seen}) - 8'sd1) age_c = r_seen - 6'd1;
        else age_c = age[5:0];
    end

    always_comb begin
        n_state = r_state; n_step = r_step; n_wptr = r_wptr; n_seen = r_seen;
        n_d = r_d; n_k = r_k; n_r = r_r; n_ovalid = r_ovalid;
        o_cmd = '0;
        o_cmd.tap_age = age_c;
        o_cmd.last_flag = i_sts.final_frame && (r_d == 5'd0);
        o_in_ready = (r_state == S_IDLE);
        if (r_ovalid && i_out_ready) n_ovalid = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load_in = 1'b1; n_step = '0; n_state = S_ATAN;
            end
            S_ATAN: begin
                o_cmd.atan_step = 1'b1;
                n_step = r_step + 5'd1;
                if (32'(r_step) == CORDIC_STEPS - 1 || r_step == 5'(TABLE_LEN - 1))
                    n_state = S_WRITE;
            end
            S_WRITE: begin
                o_cmd.ring_write = 1'b1;
                n_wptr = r_wptr + 5'd1;
                if (r_seen < 6'(HIST_CAP)) n_seen = r_seen + 6'd1;
                n_r = eff_radius;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_k = '0;
                if (i_sts.final_frame) begin
                    n_d = ({2'b0, r_r} < r_seen - 6'd1) ? {1'b0, r_r} : 5'(r_seen - 6'd1);
                    n_state = S_TAP;
                end else if (r_seen >= {2'b0, r_r} + 6'd1) begin
                    n_d = {1'b0, r_r};
                    n_state = S_TAP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TAP: begin
                // read issued this cycle, added next
                if (r_k == '0) o_cmd.acc_clear = 1'b1; else o_cmd.acc_step = 1'b1;
                if (r_k == {1'b0, r_r, 1'b0}) n_state = S_TAPLAST;
                n_k = r_k + 6'd1;
            end
            S_TAPLAST: begin
                o_cmd.acc_step = 1'b1; n_state = S_DIV; n_step = '0;
            end
            S_DIV: begin
                if (r_step == '0 && r_k != '0) begin
                    o_cmd.div_start = 1'b1; n_k = '0;
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_step = r_step + 5'd1;
                    if (r_step == 5'(DIVN - 1)) begin n_state = S_SC; n_step = '0; n_k = 6'd1; end
                end
            end
            S_SC: begin
                if (r_k != '0) begin
                    o_cmd.sc_start = 1'b1; n_k = '0;
                end else begin
                    o_cmd.sc_step = 1'b1;
                    n_step = r_step + 5'd1;
                    if (32'(r_step) == CORDIC_STEPS - 1 || r_step == 5'(TABLE_LEN - 1))
                        n_state = S_OUT;
                end
            end
            S_OUT: if (!r_ovalid || i_out_ready) begin
                o_cmd.out_load = 1'b1; n_ovalid = 1'b1; n_state = S_NEXT;
            end
            S_NEXT: begin
                n_k = '0;
                if (i_sts.final_frame && r_d != '0) begin
                    n_d = r_d - 5'd1; n_state = S_TAP;
                end else begin
                    if (i_sts.final_frame) begin n_seen = '0; n_wptr = '0; end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_step <= '0; r_wptr <= '0; r_seen <= '0;
            r_d <= '0; r_k <= '0; r_r <= '0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_step <= n_step; r_wptr <= n_wptr; r_seen <= n_seen;
            r_d <= n_d; r_k <= n_k; r_r <= n_r; r_ovalid <= n_ovalid;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_step = r_step;
    assign o_cnt  = {r_r, 1'b1};
    assign o_wptr = r_wptr;
endmodule
`default_nettype wire

/* src/trajectory_window_smoother.sv */
// Top level of the trajectory window smoother.
//
// Usage: one camera-trajectory transaction per frame on the input channel
// (i_in_valid/o_in_ready, payload i_in_item). Each sample's angle comes from an
// atan2 CORDIC; angle, x and y are averaged over a centered window of 2r+1
// frames with edge clamping and returned as a smoothed transform transaction on
// o_out_valid/i_out_ready. Results lag input by r frames; a final_frame sample
// flushes up to r+1 results, oldest first, then the history restarts.
// Sequence: after acceptance, the atan2 CORDIC runs, then the ring write and
// the decision; each result then reads its window taps through the single
// ring read port, runs the dividers (one quotient bit per cycle), the sin/cos
// CORDIC and the output load and handoff. A frame that yields no result
// returns the block to idle after the decision.
// One item is worked on at a time; o_in_ready is high only when idle.
// The output register holds a result until taken; a stalled receiver holds the
// sequencer in its output step. Reset (synchronous, active low) empties the
// history, sets r to 5 and drops o_out_valid. The user must ensure that
// i_cfg_we writes r only while idle; the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module trajectory_window_smoother #(
    parameter int MAX_RADIUS   = tws_pkg::MAX_RADIUS_DEF,
    parameter int CORDIC_STEPS = tws_pkg::CORDIC_STEPS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [3:0]           i_cfg_wdata,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  tws_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output tws_pkg::t_out_item  o_out_item
);
    import tws_pkg::*;

    logic [3:0] r_radius;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_radius <= 4'd5;
        else if (i_cfg_we) r_radius <= i_cfg_wdata;
    end

    t_cmd cmd;
    t_sts sts;
    logic [4:0] step, cnt, wptr;

    tws_ctrl #(.MAX_RADIUS(MAX_RADIUS), .CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_radius(r_radius),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(sts), .o_cmd(cmd), .o_step(step), .o_cnt(cnt), .o_wptr(wptr)
    );

    tws_datapath u_dp (
        .i_clk(i_clk), .i_item(i_in_item), .i_cmd(cmd),
        .i_step(step), .i_cnt(cnt), .i_wptr(wptr), .o_sts(sts), .o_item(o_out_item)
    );

    // A new result never overwrites one still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !cmd.out_load)
        else $error("result overwritten");
    // After an input transaction the block is busy the next cycle.
    a_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second input taken");
    // A stalled result holds its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_item))
        else $error("output changed while stalled");
endmodule
`default_nettype wire
